// ===== rtl/core/rc6_block_encrypt_macros.svh =====
// Assertion macros shared by the RC6 core
`ifndef RC6_BLOCK_ENCRYPT_MACROS_SVH
`define RC6_BLOCK_ENCRYPT_MACROS_SVH

// Implication checked every clock, off during reset
`define RC6_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rc6 check failed");

// Next-cycle implication, off during reset
`define RC6_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rc6 check failed");

`endif

// ===== rtl/core/rc6_pkg.sv =====
package rc6_pkg;

   localparam int ROUND_COUNT = 20;
   localparam int TABLE_LEN   = 2 * ROUND_COUNT + 4;
   localparam int KEY_WORDS   = 8;
   localparam int MIX_STEPS   = 3 * TABLE_LEN;
   localparam int TIDX_W      = $clog2(TABLE_LEN);
   localparam int KIDX_W      = $clog2(KEY_WORDS);
   localparam int STEP_W      = $clog2(MIX_STEPS + 1);
   localparam int CSR_IDX_W   = 4;

   localparam logic [31:0] MAGIC_P = 32'hB7E15163;
   localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_IDLE     = 4'd0,
      OP_LOAD     = 4'd1,
      OP_FILL     = 4'd2,
      OP_MIX      = 4'd3,
      OP_PRE_B    = 4'd4,
      OP_PRE_D    = 4'd5,
      OP_RND_EVEN = 4'd6,
      OP_RND_ODD  = 4'd7,
      OP_POST_A   = 4'd8,
      OP_POST_C   = 4'd9,
      OP_OUT      = 4'd10
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [TIDX_W-1:0]  tidx;   // table entry used this cycle
      logic [KIDX_W-1:0]  kidx;   // scratch word used this cycle
      logic               first;  // first mix pass takes the key registers
   } cmd_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } block_type;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] amt);
      logic [63:0] w;
      w = {v, v} << amt;
      return w[63:32];
   endfunction

endpackage

// ===== rtl/core/rc6_stream_if.sv =====
interface rc6_stream_if;
   logic                 valid;
   logic                 ready;
   rc6_pkg::block_type   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/rc6_csr_if.sv =====
interface rc6_csr_if;
   logic                            valid;
   logic                            ready;
   logic [rc6_pkg::CSR_IDX_W-1:0]   index;
   logic [31:0]                     wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/rc6_datapath.sv =====
module rc6_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  rc6_pkg::cmd_type             cmd,
   input  logic                         key_we,
   input  logic [rc6_pkg::KIDX_W-1:0]   key_idx,
   input  logic [31:0]                  key_wdata,
   input  rc6_pkg::block_type           req_block,
   output rc6_pkg::block_type           rsp_block
);

   logic [31:0] key_ff [rc6_pkg::KEY_WORDS];
   // Subkey table memory: one write, one registered read per cycle
   logic [31:0] table_mem [rc6_pkg::TABLE_LEN];
   logic [31:0] scratch_ff [rc6_pkg::KEY_WORDS];
   logic [31:0] sk_ff;
   logic [31:0] fill_ff, fill_in;
   logic [31:0] ma_ff, ma_in;
   logic [31:0] mb_ff, mb_in;
   rc6_pkg::block_type blk_ff, blk_in;
   rc6_pkg::block_type rsp_ff, rsp_in;

   logic [31:0] mix_a, mix_b, kw;
   logic [31:0] prod_b, prod_d;
   logic [31:0] t, u;

   // Key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rc6_pkg::KEY_WORDS; i++) key_ff[i] <= '0;
      end else if (key_we) begin
         key_ff[key_idx] <= key_wdata;
      end
   end

   // Key mix step; sk_ff holds the entry addressed last cycle
   always_comb begin
      kw    = (cmd.first) ? key_ff[cmd.kidx] : scratch_ff[cmd.kidx];
      mix_a = rc6_pkg::rotl32(sk_ff + ma_ff + mb_ff, 5'd3);
      mix_b = rc6_pkg::rotl32(kw + mix_a + mb_ff, mix_a[4:0] + mb_ff[4:0]);
   end

   // Round function
   always_comb begin
      prod_b = blk_ff.b * {blk_ff.b[30:0], 1'b1};
      prod_d = blk_ff.d * {blk_ff.d[30:0], 1'b1};
      t = rc6_pkg::rotl32(prod_b, 5'd5);
      u = rc6_pkg::rotl32(prod_d, 5'd5);
   end

   // Operation decode
   always_comb begin
      fill_in = fill_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      blk_in  = blk_ff;
      rsp_in  = rsp_ff;
      unique case (cmd.op)
         rc6_pkg::OP_LOAD: begin
            blk_in  = req_block;
            fill_in = rc6_pkg::MAGIC_P;
            ma_in   = '0;
            mb_in   = '0;
         end
         rc6_pkg::OP_FILL:
            fill_in = fill_ff + rc6_pkg::MAGIC_Q;
         rc6_pkg::OP_MIX: begin
            ma_in = mix_a;
            mb_in = mix_b;
         end
         rc6_pkg::OP_PRE_B:
            blk_in.b = blk_ff.b + sk_ff;
         rc6_pkg::OP_PRE_D:
            blk_in.d = blk_ff.d + sk_ff;
         rc6_pkg::OP_RND_EVEN: begin
            // new a parks in the a slot until the odd step rotates the words
            blk_in.a = rc6_pkg::rotl32(blk_ff.a ^ t, u[4:0]) + sk_ff;
            blk_in.c = rc6_pkg::rotl32(blk_ff.c ^ u, t[4:0]);
         end
         rc6_pkg::OP_RND_ODD: begin
            blk_in.a = blk_ff.b;
            blk_in.b = blk_ff.c + sk_ff;
            blk_in.c = blk_ff.d;
            blk_in.d = blk_ff.a;
         end
         rc6_pkg::OP_POST_A:
            blk_in.a = blk_ff.a + sk_ff;
         rc6_pkg::OP_POST_C:
            blk_in.c = blk_ff.c + sk_ff;
         rc6_pkg::OP_OUT:
            rsp_in = blk_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      fill_ff <= fill_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      blk_ff  <= blk_in;
      rsp_ff  <= rsp_in;
      if (cmd.op == rc6_pkg::OP_MIX)
         scratch_ff[cmd.kidx] <= mix_b;
   end

   // Subkey table access
   always_ff @(posedge clock) begin
      sk_ff <= table_mem[cmd.tidx];
      if (cmd.op == rc6_pkg::OP_FILL)
         table_mem[cmd.tidx] <= fill_ff;
      else if (cmd.op == rc6_pkg::OP_MIX)
         table_mem[cmd.tidx] <= mix_a;
   end

   assign rsp_block = rsp_ff;

endmodule

// ===== rtl/core/rc6_top_dummy.sv =====
module rc6_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              key_write,
   output rc6_pkg::cmd_type  cmd
);
   `include "rc6_block_encrypt_macros.svh"

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_FILL  = 7'b0000010,
      ST_MRD   = 7'b0000100,
      ST_MWR   = 7'b0001000,
      ST_RRD   = 7'b0010000,
      ST_RWR   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic sched_ok_ff, sched_ok_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [rc6_pkg::TIDX_W-1:0] tidx_ff, tidx_in;
   logic [rc6_pkg::KIDX_W-1:0] kidx_ff, kidx_in;
   logic [rc6_pkg::STEP_W-1:0] step_ff, step_in;
   logic first_ff, first_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequencing and commands
   always_comb begin
      state_in = state_ff; tidx_in = tidx_ff; kidx_in = kidx_ff;
      step_in = step_ff; first_in = first_ff;
      sched_ok_in = sched_ok_ff; rsp_valid_in = rsp_valid_ff;
      cmd.op = rc6_pkg::OP_IDLE; cmd.tidx = tidx_ff; cmd.kidx = kidx_ff;
      cmd.first = first_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.op = rc6_pkg::OP_LOAD;
            tidx_in = '0; kidx_in = '0; step_in = '0; first_in = 1'b1;
            state_in = sched_ok_ff ? ST_RRD : ST_FILL;
         end
         ST_FILL: begin
            cmd.op = rc6_pkg::OP_FILL;
            if (tidx_ff == rc6_pkg::TIDX_W'(rc6_pkg::TABLE_LEN - 1)) begin
               tidx_in = '0; state_in = ST_MRD;
            end else tidx_in = tidx_ff + rc6_pkg::TIDX_W'(1);
         end
         ST_MRD: state_in = ST_MWR;
         ST_MWR: begin
            cmd.op = rc6_pkg::OP_MIX;
            step_in = step_ff + rc6_pkg::STEP_W'(1);
            kidx_in = kidx_ff + rc6_pkg::KIDX_W'(1);
            if (kidx_ff == rc6_pkg::KIDX_W'(rc6_pkg::KEY_WORDS - 1)) first_in = 1'b0;
            tidx_in = (tidx_ff == rc6_pkg::TIDX_W'(rc6_pkg::TABLE_LEN - 1)) ? '0
                      : tidx_ff + rc6_pkg::TIDX_W'(1);
            if (step_ff == rc6_pkg::STEP_W'(rc6_pkg::MIX_STEPS - 1)) begin
               sched_ok_in = 1'b1; tidx_in = '0; state_in = ST_RRD;
            end else state_in = ST_MRD;
         end
         ST_RRD: state_in = ST_RWR;
         ST_RWR: begin
            // subkey index tidx_ff: 0,1 pre-white; 2r,2r+1 round; last two post
            tidx_in = tidx_ff + rc6_pkg::TIDX_W'(1); state_in = ST_RRD;
            if (tidx_ff == '0) cmd.op = rc6_pkg::OP_PRE_B;
            else if (tidx_ff == rc6_pkg::TIDX_W'(1)) cmd.op = rc6_pkg::OP_PRE_D;
            else if (tidx_ff == rc6_pkg::TIDX_W'(rc6_pkg::TABLE_LEN - 2))
               cmd.op = rc6_pkg::OP_POST_A;
            else if (tidx_ff == rc6_pkg::TIDX_W'(rc6_pkg::TABLE_LEN - 1)) begin
               cmd.op = rc6_pkg::OP_POST_C; state_in = ST_OUT;
            end else if (!tidx_ff[0]) cmd.op = rc6_pkg::OP_RND_EVEN;
            else cmd.op = rc6_pkg::OP_RND_ODD;
         end
         ST_OUT: begin
            // wait here while the previous response is still held
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op = rc6_pkg::OP_OUT; rsp_valid_in = 1'b1; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (key_write) sched_ok_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; sched_ok_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; sched_ok_ff <= sched_ok_in; rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Counters
   always_ff @(posedge clock) begin
      tidx_ff <= tidx_in; kidx_ff <= kidx_in; step_ff <= step_in;
      first_ff <= first_in;
   end

   `RC6_ASSERT_IMP(a_no_req_busy, clock, reset, state_ff != ST_IDLE, !req_ready)
   `RC6_ASSERT_NEXT(a_out_valid, clock, reset, state_ff == ST_OUT, rsp_valid_ff)
   `RC6_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff)
   `RC6_ASSERT_IMP(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
endmodule

// ===== rtl/core/rc6_block_encrypt.sv =====
// RC6-32/20/32 encryption core. Write the 256-bit key through csr_ (eight
// little-endian words, index 0..7); requests carry one 128-bit plaintext
// block, responses the ciphertext. A block runs a load step, then for each
// of the 2*ROUND_COUNT+4 = 44 subkeys a table read and the add or half round
// that uses it, and last a move of the result into the output register,
// which raises the response valid. The first block after reset or a key
// write first runs the schedule: 44 fill steps, then 132 mix steps, each a
// table read and then a write. A new request is taken while the last
// response waits; the core then holds in its output state until it is taken.
module rc6_block_encrypt (
   input  logic             clock,
   input  logic             reset,
   rc6_stream_if.sink       req,
   rc6_stream_if.source     rsp,
   rc6_csr_if.sink          csr
);

   rc6_pkg::cmd_type cmd;
   logic key_write;

   assign csr.ready = 1'b1;
   assign key_write = csr.valid && csr.ready &&
                      (csr.index < rc6_pkg::CSR_IDX_W'(rc6_pkg::KEY_WORDS));

   // Controller
   rc6_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .key_write (key_write),
      .cmd       (cmd)
   );

   // Datapath
   rc6_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .key_we    (key_write),
      .key_idx   (csr.index[rc6_pkg::KIDX_W-1:0]),
      .key_wdata (csr.wdata),
      .req_block (req.data),
      .rsp_block (rsp.data)
   );

endmodule
